FILE: hw/rtl/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg: shared types and constants of the double-ended queue
// Command and status codes, cell operations and the control state type.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEPTH_DEF       = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int CMD_W    = 3;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_LIST_FWD   = 3'd4,
        CMD_LIST_REV   = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_EMPTY    = 2'd1,
        STATUS_FULL     = 2'd2,
        STATUS_NO_MATCH = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_SHIFT_RIGHT,
        OP_APPEND,
        OP_SHIFT_LEFT,
        OP_ROT_LEFT,
        OP_ROT_RIGHT
    } cell_op_t;

    // Per-cell control: the shared operation plus flags derived from the count
    typedef struct packed {
        cell_op_t op;
        logic     occ;
        logic     tail;
        logic     append;
    } cell_ctrl_t;

    typedef enum logic {
        ST_IDLE,
        ST_LIST
    } state_t;

endpackage

FILE: hw/rtl/deq_req_if.sv
// ----------------------------------------------------------------------------
// deq_req_if: command channel of the double-ended queue
// Valid/ready channel carrying one command word.
// ----------------------------------------------------------------------------
interface deq_req_if
    import deq_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
);
    logic                   valid;
    logic                   ready;
    logic [CMD_W-1:0]       command;
    logic [VALUE_WIDTH-1:0] entry_value;
    logic [POS_W-1:0]       position_bound;

    modport source (output valid, command, entry_value, position_bound, input ready);
    modport sink   (input valid, command, entry_value, position_bound, output ready);
endinterface

FILE: hw/rtl/deq_rsp_if.sv
// ----------------------------------------------------------------------------
// deq_rsp_if: result channel of the double-ended queue
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface deq_rsp_if
    import deq_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
);
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] result_value;
    logic [POS_W-1:0]       result_position;
    logic [STATUS_W-1:0]    status;
    logic                   last_of_run;

    modport source (output valid, result_value, result_position, status, last_of_run,
                    input ready);
    modport sink   (input valid, result_value, result_position, status, last_of_run,
                    output ready);
endinterface

FILE: hw/rtl/deq_cell.sv
// ----------------------------------------------------------------------------
// deq_cell: one storage cell of the queue chain
// Holds one entry and takes its next value from a neighbour, the head,
// or the incoming word, as the shared operation directs.
// ----------------------------------------------------------------------------
module deq_cell
    import deq_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic                   clk,
    input  cell_ctrl_t             ctrl,
    input  logic [VALUE_WIDTH-1:0] left_val,
    input  logic [VALUE_WIDTH-1:0] right_val,
    input  logic [VALUE_WIDTH-1:0] head_val,
    input  logic [VALUE_WIDTH-1:0] entry_val,
    output logic [VALUE_WIDTH-1:0] val
);

    logic [VALUE_WIDTH-1:0] val_reg;
    logic [VALUE_WIDTH-1:0] val_next;

    always_comb
    begin
        val_next = val_reg;
        unique case (ctrl.op)
            OP_HOLD:        val_next = val_reg;
            OP_SHIFT_RIGHT: val_next = left_val;
            OP_APPEND:
            begin
                if (ctrl.append)
                begin
                    val_next = entry_val;
                end
            end
            OP_SHIFT_LEFT:  val_next = right_val;
            OP_ROT_LEFT:
            begin
                // the back entry wraps round to take the head
                if (ctrl.occ)
                begin
                    val_next = ctrl.tail ? head_val : right_val;
                end
            end
            OP_ROT_RIGHT:
            begin
                if (ctrl.occ)
                begin
                    val_next = left_val;
                end
            end
            default:        val_next = val_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

FILE: hw/rtl/double_ended_queue_top.sv
// ----------------------------------------------------------------------------
// double_ended_queue_top: bounded double-ended queue on a chain of cells
// Entries sit packed from cell 0 (front) onwards; front pushes and pops
// shift the chain, back ones do not; listings rotate it round to its start.
// ----------------------------------------------------------------------------
// Push and pop commands each give one result word. A listing is accepted and
// then takes one rotation step per live entry: the chain rotates one step a
// cycle while the result register is free, and the head or tail cell is read
// out; matching entries leave at one word a cycle while it is free, and an
// unmatched listing answers with one no-match status word. A new command is
// taken only once the previous one is finished and the result register is
// free or draining. Unused command codes are taken and give no result.
module double_ended_queue_top
    import deq_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    deq_req_if.sink   request,
    deq_rsp_if.source response
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    logic [CW-1:0]          count_reg, count_next;
    logic [CW-1:0]          pos_reg, pos_next;
    logic [POS_W-1:0]       bound_reg, bound_next;
    logic                   dir_rev_reg, dir_rev_next;
    state_t                 state_reg, state_next;

    logic                   out_valid_reg, out_valid_next;
    logic [VALUE_WIDTH-1:0] out_value_reg, out_value_next;
    logic [POS_W-1:0]       out_pos_reg, out_pos_next;
    status_t                out_status_reg, out_status_next;
    logic                   out_last_reg, out_last_next;

    cell_op_t               op;
    cell_ctrl_t             ctrl [DEPTH];
    logic [VALUE_WIDTH-1:0] cell_val [DEPTH];
    logic [VALUE_WIDTH-1:0] head_val;
    logic [VALUE_WIDTH-1:0] tail_val;
    logic [VALUE_WIDTH-1:0] first_left_val;

    logic                   slot_free;
    logic                   accept;
    cmd_t                   cmd;
    logic [CMPW-1:0]        count_ext, pos_ext, bound_in_ext, bound_ext;
    logic                   step_emit;
    logic                   step_last;

    // ------------------------------------------------------------------
    // cell chain
    // ------------------------------------------------------------------
    assign head_val       = cell_val[0];
    assign first_left_val = (op == OP_ROT_RIGHT) ? tail_val : request.entry_value;

    always_comb
    begin
        tail_val = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (ctrl[i].tail)
            begin
                tail_val = tail_val | cell_val[i];
            end
        end
    end

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        assign ctrl[g].op     = op;
        assign ctrl[g].occ    = CW'(g) < count_reg;
        assign ctrl[g].tail   = CW'(g + 1) == count_reg;
        assign ctrl[g].append = CW'(g) == count_reg;

        deq_cell #(
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl[g]),
            .left_val  ((g == 0) ? first_left_val : cell_val[(g == 0) ? 0 : g - 1]),
            .right_val ((g == DEPTH - 1) ? cell_val[g] : cell_val[(g == DEPTH - 1) ? g : g + 1]),
            .head_val  (head_val),
            .entry_val (request.entry_value),
            .val       (cell_val[g])
        );
    end

    // ------------------------------------------------------------------
    // control
    // ------------------------------------------------------------------
    assign slot_free     = !out_valid_reg || response.ready;
    assign request.ready = (state_reg == ST_IDLE) && slot_free;
    assign accept        = request.valid && request.ready;
    assign cmd           = cmd_t'(request.command);

    assign count_ext    = CMPW'(count_reg);
    assign pos_ext      = CMPW'(pos_reg);
    assign bound_in_ext = CMPW'(request.position_bound);
    assign bound_ext    = CMPW'(bound_reg);

    assign step_emit = dir_rev_reg ? (pos_ext <= bound_ext) : (pos_ext >= bound_ext);
    assign step_last = dir_rev_reg ? (pos_reg == CW'(1)) : (pos_reg == count_reg);

    always_comb
    begin
        op              = OP_HOLD;
        count_next      = count_reg;
        pos_next        = pos_reg;
        bound_next      = bound_reg;
        dir_rev_next    = dir_rev_reg;
        state_next      = state_reg;
        out_valid_next  = out_valid_reg && !response.ready;
        out_value_next  = out_value_reg;
        out_pos_next    = out_pos_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    // most commands answer with a bare status word
                    out_value_next  = '0;
                    out_pos_next    = '0;
                    out_status_next = STATUS_OK;
                    out_last_next   = 1'b1;
                    case (cmd)
                        CMD_PUSH_FRONT, CMD_PUSH_BACK:
                        begin
                            out_valid_next = 1'b1;
                            if (count_reg == CW'(DEPTH))
                            begin
                                out_status_next = STATUS_FULL;
                            end
                            else
                            begin
                                op         = (cmd == CMD_PUSH_FRONT) ? OP_SHIFT_RIGHT
                                                                     : OP_APPEND;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        CMD_POP_FRONT, CMD_POP_BACK:
                        begin
                            out_valid_next = 1'b1;
                            if (count_reg == '0)
                            begin
                                out_status_next = STATUS_EMPTY;
                            end
                            else if (cmd == CMD_POP_FRONT)
                            begin
                                op             = OP_SHIFT_LEFT;
                                out_value_next = head_val;
                                out_pos_next   = POS_W'(1);
                                count_next     = count_reg - CW'(1);
                            end
                            else
                            begin
                                out_value_next = tail_val;
                                out_pos_next   = POS_W'(count_reg);
                                count_next     = count_reg - CW'(1);
                            end
                        end
                        CMD_LIST_FWD:
                        begin
                            if (count_reg != '0 && bound_in_ext <= count_ext)
                            begin
                                state_next   = ST_LIST;
                                dir_rev_next = 1'b0;
                                pos_next     = CW'(1);
                                bound_next   = request.position_bound;
                            end
                            else
                            begin
                                out_valid_next  = 1'b1;
                                out_status_next = STATUS_NO_MATCH;
                            end
                        end
                        CMD_LIST_REV:
                        begin
                            if (count_reg != '0 && request.position_bound != '0)
                            begin
                                state_next   = ST_LIST;
                                dir_rev_next = 1'b1;
                                pos_next     = count_reg;
                                bound_next   = request.position_bound;
                            end
                            else
                            begin
                                out_valid_next  = 1'b1;
                                out_status_next = STATUS_NO_MATCH;
                            end
                        end
                        default:
                        begin
                            // unused code: drop silently
                        end
                    endcase
                end
            end
            ST_LIST:
            begin
                // advance one rotation step whenever the result register is free
                if (slot_free)
                begin
                    op = dir_rev_reg ? OP_ROT_RIGHT : OP_ROT_LEFT;
                    if (step_emit)
                    begin
                        out_valid_next  = 1'b1;
                        out_value_next  = dir_rev_reg ? tail_val : head_val;
                        out_pos_next    = POS_W'(pos_reg);
                        out_status_next = STATUS_OK;
                        out_last_next   = step_last;
                    end
                    if (step_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        pos_next = dir_rev_reg ? pos_reg - CW'(1) : pos_reg + CW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        bound_reg      <= bound_next;
        dir_rev_reg    <= dir_rev_next;
        out_value_reg  <= out_value_next;
        out_pos_reg    <= out_pos_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    assign response.valid           = out_valid_reg;
    assign response.result_value    = out_value_reg;
    assign response.result_position = out_pos_reg;
    assign response.status          = out_status_reg;
    assign response.last_of_run     = out_last_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count beyond depth");

    a_count_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        !(request.valid && request.ready) |=> $stable(count_reg))
        else $error("entry count changed without a command");

    a_list_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LIST) |-> (count_reg != '0))
        else $error("listing walk on an empty queue");

endmodule

FILE: verif/tb_double_ended_queue_top.sv
// ----------------------------------------------------------------------------
// tb_double_ended_queue_top: self-checking bench for the double-ended queue
// Drives push, pop and listing commands through the request channel and
// checks every result word against a ring-buffer model of the deque or a typed-in
// result. A short stimulus table covers the edge cases first; a long random
// run follows. Both sides of the handshake idle at random.
// ----------------------------------------------------------------------------
module tb_double_ended_queue_top;
    import deq_pkg::*;

    localparam int DEPTH            = DEPTH_DEF;
    localparam int VALUE_W          = VALUE_WIDTH_DEF;
    localparam int RANDOM_WORDS     = 340;
    localparam int REPORT_LIMIT     = 10;
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int DRAIN_LIMIT      = 20000;
    localparam int TAIL_CYCLES      = 2 * DEPTH + 8;
    localparam int NUM_ROWS         = 25;

    localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   position;
        status_t            status;
        logic               last;
    } deq_result_t;

    // One table row; rv/rp/st are the typed-in result when typed is set
    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   bound;
        logic [4:0]         reps;
        logic               typed;
        status_t            st;
        logic [VALUE_W-1:0] rv;
        logic [POS_W-1:0]   rp;
    } stim_row_t;

    typedef enum logic [1:0] {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } mix_t;

    localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        '{CMD_POP_FRONT,  32'h0,        5'd0,  5'd1,  1'b1, STATUS_EMPTY,    32'h0,        5'd0},
        '{CMD_POP_BACK,   32'h0,        5'd0,  5'd1,  1'b1, STATUS_EMPTY,    32'h0,        5'd0},
        '{CMD_LIST_FWD,   32'h0,        5'd0,  5'd1,  1'b1, STATUS_NO_MATCH, 32'h0,        5'd0},
        '{CMD_LIST_REV,   32'h0,        5'd16, 5'd1,  1'b1, STATUS_NO_MATCH, 32'h0,        5'd0},
        '{CMD_PUSH_FRONT, 32'hFFFFFFFF, 5'd31, 5'd1,  1'b1, STATUS_OK,       32'h0,        5'd0},
        '{CMD_PUSH_BACK,  32'h00000000, 5'd0,  5'd1,  1'b1, STATUS_OK,       32'h0,        5'd0},
        '{CMD_PUSH_FRONT, 32'h5A5A5A5A, 5'd0,  5'd1,  1'b1, STATUS_OK,       32'h0,        5'd0},
        '{CMD_LIST_FWD,   32'h0,        5'd0,  5'd1,  1'b0, STATUS_OK,       32'h0,        5'd0},
        '{CMD_LIST_FWD,   32'h0,        5'd16, 5'd1,  1'b1, STATUS_NO_MATCH, 32'h0,        5'd0},
        '{CMD_LIST_REV,   32'h0,        5'd0,  5'd1,  1'b1, STATUS_NO_MATCH, 32'h0,        5'd0},
        '{CMD_LIST_REV,   32'h0,        5'd16, 5'd1,  1'b0, STATUS_OK,       32'h0,        5'd0},
        '{CMD_LIST_FWD,   32'h0,        5'd2,  5'd1,  1'b0, STATUS_OK,       32'h0,        5'd0},
        '{CMD_LIST_REV,   32'h0,        5'd2,  5'd1,  1'b0, STATUS_OK,       32'h0,        5'd0},
        '{CMD_UNUSED_6,   32'hFFFFFFFF, 5'd15, 5'd1,  1'b0, STATUS_OK,       32'h0,        5'd0},
        '{CMD_UNUSED_7,   32'h0,        5'd0,  5'd1,  1'b0, STATUS_OK,       32'h0,        5'd0},
        '{CMD_POP_FRONT,  32'h0,        5'd0,  5'd1,  1'b1, STATUS_OK,       32'h5A5A5A5A, 5'd1},
        '{CMD_POP_BACK,   32'h0,        5'd0,  5'd1,  1'b1, STATUS_OK,       32'h00000000, 5'd2},
        '{CMD_PUSH_BACK,  32'h80000000, 5'd0,  5'd15, 1'b1, STATUS_OK,       32'h0,        5'd0},
        '{CMD_PUSH_FRONT, 32'h12345678, 5'd0,  5'd1,  1'b1, STATUS_FULL,     32'h0,        5'd0},
        '{CMD_PUSH_BACK,  32'h87654321, 5'd0,  5'd1,  1'b1, STATUS_FULL,     32'h0,        5'd0},
        '{CMD_LIST_FWD,   32'h0,        5'd16, 5'd1,  1'b0, STATUS_OK,       32'h0,        5'd0},
        '{CMD_LIST_REV,   32'h0,        5'd1,  5'd1,  1'b0, STATUS_OK,       32'h0,        5'd0},
        '{CMD_LIST_REV,   32'h0,        5'd16, 5'd1,  1'b0, STATUS_OK,       32'h0,        5'd0},
        '{CMD_POP_BACK,   32'h0,        5'd0,  5'd8,  1'b0, STATUS_OK,       32'h0,        5'd0},
        '{CMD_POP_FRONT,  32'h0,        5'd0,  5'd9,  1'b0, STATUS_OK,       32'h0,        5'd0}
    };

    logic clk = 1'b0;
    logic rst_n;

    deq_req_if #(.VALUE_WIDTH(VALUE_W)) request ();
    deq_rsp_if #(.VALUE_WIDTH(VALUE_W)) response ();

    double_ended_queue_top #(
        .DEPTH      (DEPTH),
        .VALUE_WIDTH(VALUE_W)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .response(response)
    );

    // Deque model: ring of words, head slot and live count
    logic [VALUE_W-1:0] ring_words [DEPTH];
    int unsigned        ring_head;
    int unsigned        live_count;

    deq_result_t predicted [$];
    deq_result_t expected_results [$];

    int  send_idle_pct;
    int  recv_idle_pct;
    bit  long_hold_pending;
    int  hold_left;
    int  mismatch_count;
    int  results_checked;
    int  commands_sent;
    int  listings_sent;
    int  full_seen;
    int  empty_seen;

    always #6 clk = ~clk;

    function automatic deq_result_t make_result(input logic [VALUE_W-1:0] value,
                                                input logic [POS_W-1:0]   position,
                                                input status_t            status,
                                                input logic               last);
        deq_result_t r;
        r.value    = value;
        r.position = position;
        r.status   = status;
        r.last     = last;
        return r;
    endfunction

    function automatic logic [VALUE_W-1:0] word_at(input int unsigned position);
        return ring_words[(ring_head + position - 1) % DEPTH];
    endfunction

    // Apply one command to the model and leave its result words in predicted
    function automatic void predict_command(input logic [CMD_W-1:0]   cmd,
                                            input logic [VALUE_W-1:0] value,
                                            input logic [POS_W-1:0]   bound);
        int unsigned p;
        predicted.delete();
        case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK:
            begin
                if (live_count == DEPTH)
                begin
                    predicted.push_back(make_result('0, '0, STATUS_FULL, 1'b1));
                    full_seen++;
                end
                else
                begin
                    if (cmd == CMD_PUSH_FRONT)
                    begin
                        ring_head = (ring_head + DEPTH - 1) % DEPTH;
                        ring_words[ring_head] = value;
                    end
                    else
                    begin
                        ring_words[(ring_head + live_count) % DEPTH] = value;
                    end
                    live_count++;
                    predicted.push_back(make_result('0, '0, STATUS_OK, 1'b1));
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK:
            begin
                if (live_count == 0)
                begin
                    predicted.push_back(make_result('0, '0, STATUS_EMPTY, 1'b1));
                    empty_seen++;
                end
                else
                begin
                    if (cmd == CMD_POP_FRONT)
                    begin
                        predicted.push_back(make_result(word_at(1), 5'd1, STATUS_OK, 1'b1));
                        ring_head = (ring_head + 1) % DEPTH;
                    end
                    else
                    begin
                        predicted.push_back(make_result(word_at(live_count),
                                                        POS_W'(live_count), STATUS_OK, 1'b1));
                    end
                    live_count--;
                end
            end
            CMD_LIST_FWD, CMD_LIST_REV:
            begin
                listings_sent++;
                for (p = 1; p <= live_count; p++)
                begin
                    if (cmd == CMD_LIST_FWD && p >= bound)
                        predicted.push_back(make_result(word_at(p), POS_W'(p), STATUS_OK, 1'b0));
                end
                for (p = live_count; p >= 1; p--)
                begin
                    if (cmd == CMD_LIST_REV && p <= bound)
                        predicted.push_back(make_result(word_at(p), POS_W'(p), STATUS_OK, 1'b0));
                end
                if (predicted.size() == 0)
                    predicted.push_back(make_result('0, '0, STATUS_NO_MATCH, 1'b1));
                else
                    predicted[predicted.size() - 1].last = 1'b1;
            end
            default:
            begin
            end
        endcase
    endfunction

    // Offer one command word, hold it until taken, then record what it should give
    task automatic send_command(input logic [CMD_W-1:0]   cmd,
                                input logic [VALUE_W-1:0] value,
                                input logic [POS_W-1:0]   bound,
                                input logic               typed,
                                input deq_result_t        typed_result);
        while ($urandom_range(99) < send_idle_pct)
        begin
            request.valid <= 1'b0;
            @(posedge clk);
        end
        request.valid          <= 1'b1;
        request.command        <= cmd;
        request.entry_value    <= value;
        request.position_bound <= bound;
        @(posedge clk);
        while (!request.ready)
            @(posedge clk);
        predict_command(cmd, value, bound);
        if (typed)
            expected_results.push_back(typed_result);
        else
            foreach (predicted[k])
                expected_results.push_back(predicted[k]);
        commands_sent++;
    endtask

    task automatic flag_mismatch(input string reason, input deq_result_t got,
                                 input deq_result_t want);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("mismatch: %s: got value %h pos %0d status %0d last %b,",
                     reason, got.value, got.position, got.status, got.last,
                     " expected value %h pos %0d status %0d last %b",
                     want.value, want.position, want.status, want.last);
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    always @(posedge clk)
    begin
        if (long_hold_pending)
        begin
            long_hold_pending = 1'b0;
            hold_left = LONG_HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            response.ready <= 1'b0;
        end
        else
        begin
            response.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : check_results
        deq_result_t got;
        if (rst_n && response.valid && response.ready)
        begin
            got = make_result(response.result_value, response.result_position,
                              status_t'(response.status), response.last_of_run);
            if (expected_results.size() == 0)
                flag_mismatch("unexpected word", got, '0);
            else if (got !== expected_results[0])
                flag_mismatch("wrong word", got, expected_results.pop_front());
            else
                void'(expected_results.pop_front());
            results_checked++;
        end
    end

    initial
    begin
        #(12 * 600000);
        $display("FAIL double_ended_queue_top");
        $finish;
    end

    initial
    begin : stimulus
        logic [CMD_W-1:0]   cmd;
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   bound;
        mix_t               mix;
        int                 roll;
        int                 push_cut;
        int                 pop_cut;
        int                 random_done;
        int                 phase;
        int                 waited;
        int                 bound_cap;

        rst_n                  = 1'b0;
        request.valid          = 1'b0;
        request.command        = '0;
        request.entry_value    = '0;
        request.position_bound = '0;
        response.ready         = 1'b0;
        ring_head              = 0;
        live_count             = 0;
        hold_left              = 0;
        long_hold_pending      = 1'b0;
        send_idle_pct          = 21;
        recv_idle_pct          = 65;
        mix                    = MIX_EVEN;
        random_done            = 0;
        phase                  = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < NUM_ROWS; r++)
        begin
            for (int k = 0; k < DIRECTED_ROWS[r].reps; k++)
                send_command(DIRECTED_ROWS[r].cmd, DIRECTED_ROWS[r].value + VALUE_W'(k),
                             DIRECTED_ROWS[r].bound, DIRECTED_ROWS[r].typed,
                             make_result(DIRECTED_ROWS[r].rv, DIRECTED_ROWS[r].rp,
                                         DIRECTED_ROWS[r].st, 1'b1));
        end

        while (random_done < RANDOM_WORDS)
        begin
            if (phase == 0 && random_done >= RANDOM_WORDS / 3)
            begin
                phase = 1;
                send_idle_pct = 65;
                recv_idle_pct = 21;
            end
            else if (phase == 1 && random_done >= 2 * RANDOM_WORDS / 3)
            begin
                // no idling from here; stall the result side for a while
                phase = 2;
                send_idle_pct = 0;
                recv_idle_pct = 0;
                long_hold_pending = 1'b1;
            end

            // drift between filling, draining and a balanced mix
            if ($urandom_range(29) == 0)
                mix = mix_t'($urandom_range(2));
            case (mix)
                MIX_FILL:  begin push_cut = 63; pop_cut = 80; end
                MIX_DRAIN: begin push_cut = 23; pop_cut = 80; end
                default:   begin push_cut = 40; pop_cut = 75; end
            endcase

            roll = $urandom_range(99);
            if (roll < 3)
                cmd = $urandom_range(1) ? CMD_UNUSED_6 : CMD_UNUSED_7;
            else if (roll < push_cut)
                cmd = $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
            else if (roll < pop_cut)
                cmd = $urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK;
            else
                cmd = $urandom_range(1) ? CMD_LIST_FWD : CMD_LIST_REV;

            case ($urandom_range(9))
                0:       value = '0;
                1:       value = '1;
                default: value = VALUE_W'($urandom);
            endcase

            bound_cap = (live_count + 1 > DEPTH) ? DEPTH : live_count + 1;
            if ($urandom_range(3) == 0)
                bound = POS_W'($urandom_range(DEPTH));
            else
                bound = POS_W'($urandom_range(bound_cap));

            send_command(cmd, value, bound, 1'b0, '0);
            if (cmd != CMD_UNUSED_6 && cmd != CMD_UNUSED_7)
                random_done++;
        end
        request.valid <= 1'b0;

        waited = 0;
        while (expected_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (expected_results.size() != 0)
        begin
            mismatch_count += expected_results.size();
            $display("%0d expected result words never arrived", expected_results.size());
        end

        $display("Ran %0d commands (%0d listings, %0d rejected as full, %0d as empty).",
                 commands_sent, listings_sent, full_seen, empty_seen);
        $display("Checked %0d result words, %0d mismatches.", results_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("PASS double_ended_queue_top");
        else
            $display("FAIL double_ended_queue_top");
        $finish;
    end

endmodule

FILE: double_ended_queue_top.f
hw/rtl/deq_pkg.sv
hw/rtl/deq_req_if.sv
hw/rtl/deq_rsp_if.sv
hw/rtl/deq_cell.sv
hw/rtl/double_ended_queue_top.sv
verif/tb_double_ended_queue_top.sv
